// ===== hw/rtl/crarmt_pkg.sv =====
// ----------------------------------------------------------------------------
// crarmt_pkg
// Shared types and constants for the circular range-add / range-min tree.
// ----------------------------------------------------------------------------
package crarmt_pkg;

    localparam int MAX_LENGTH  = 1024;
    localparam int VALUE_WIDTH = 48;
    localparam int LEN_W       = 11;
    localparam int IDX_W       = 10;
    localparam int ACT_W       = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_UNUSED = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        PH_ENTER,
        PH_RIGHT,
        PH_POST
    } phase_t;

    typedef enum logic [1:0] {
        OP_BUILD,
        OP_ADD,
        OP_QUERY
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUILD,
        ST_PASS0,
        ST_PASS1,
        ST_VISIT,
        ST_NODE,
        ST_PD_WR0,
        ST_PD_WR1,
        ST_LEAF_RD,
        ST_LEAF_WR,
        ST_POST_RD1,
        ST_POST_WR,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_BUILD,
        CMD_PASS0,
        CMD_PASS1,
        CMD_RD_NODE,
        CMD_RD_STG,
        CMD_WR_LEAF,
        CMD_COVER_ADD,
        CMD_COVER_QRY,
        CMD_POP,
        CMD_SAVE_PEND,
        CMD_WR_C0,
        CMD_WR_C1,
        CMD_DESC0,
        CMD_DESC1,
        CMD_RD_C0,
        CMD_RD_C1,
        CMD_WR_POST,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic   clear_done;
        logic   empty;
        phase_t phase;
        logic   leaf;
        logic   covered;
        logic   disjoint;
        logic   pend_nz;
        logic   wrap;
        logic   out_busy;
    } status_t;

endpackage

// ===== hw/rtl/circular_range_add_range_min_tree.sv =====
// ----------------------------------------------------------------------------
// circular_range_add_range_min_tree
// Add and query visit the tree node by node: disjoint nodes are skipped, covered nodes
// are updated, split nodes push any pending addend down and descend into both children;
// a wrapped range runs both passes. Build writes each leaf from the staged elements.
// Throughput: one transaction in flight; a finished result waits in the output register.
// After reset the block clears pending addends and staged elements before it accepts input.
// ----------------------------------------------------------------------------
module circular_range_add_range_min_tree #(
    parameter int MAX_LENGTH  = crarmt_pkg::MAX_LENGTH,
    parameter int VALUE_WIDTH = crarmt_pkg::VALUE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [crarmt_pkg::ACT_W-1:0]   s_action,
    input  logic [crarmt_pkg::IDX_W-1:0]   s_left,
    input  logic [crarmt_pkg::IDX_W-1:0]   s_right,
    input  logic signed [VALUE_WIDTH-1:0]  s_value,
    input  logic                           s_last_load,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [VALUE_WIDTH-1:0]  m_min_value,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crarmt_pkg::APB_AW-1:0]  paddr,
    input  logic [crarmt_pkg::APB_DW-1:0]  pwdata,
    output logic [crarmt_pkg::APB_DW-1:0]  prdata,
    output logic                           pready
);

    logic [crarmt_pkg::LEN_W-1:0] len_reg;
    crarmt_pkg::cmd_t             cmd;
    crarmt_pkg::status_t          status;

    assign pready = 1'b1;
    assign prdata = {{(crarmt_pkg::APB_DW - crarmt_pkg::LEN_W){1'b0}}, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= crarmt_pkg::LEN_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            len_reg <= pwdata[crarmt_pkg::LEN_W-1:0];
        end
    end

    crarmt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_action    (s_action),
        .s_last_load (s_last_load),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    crarmt_dp #(
        .MAX_LENGTH  (MAX_LENGTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_action     (s_action),
        .s_left       (s_left),
        .s_right      (s_right),
        .s_value      (s_value),
        .array_length (len_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_min_value  (m_min_value)
    );

endmodule

// ===== hw/rtl/crarmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// crarmt_ctrl
// Sequencer for tree build, range add and range min traversals.
// ----------------------------------------------------------------------------
module crarmt_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic [crarmt_pkg::ACT_W-1:0] s_action,
    input  logic                       s_last_load,
    output logic                       s_ready,
    input  crarmt_pkg::status_t        status,
    output crarmt_pkg::cmd_t           cmd
);

    crarmt_pkg::state_t state_reg, state_next;
    crarmt_pkg::op_t    op_reg, op_next;
    logic               pass1_reg, pass1_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crarmt_pkg::ST_CLEAR;
            op_reg    <= crarmt_pkg::OP_BUILD;
            pass1_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            pass1_reg <= pass1_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        pass1_next = pass1_reg;
        cmd        = crarmt_pkg::CMD_NOP;
        s_ready    = 1'b0;
        case (state_reg)
            crarmt_pkg::ST_CLEAR: begin
                cmd = crarmt_pkg::CMD_CLEAR;
                if (status.clear_done) begin
                    state_next = crarmt_pkg::ST_IDLE;
                end
            end
            crarmt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd = crarmt_pkg::CMD_ACCEPT;
                    case (s_action)
                        crarmt_pkg::ACT_LOAD: begin
                            if (s_last_load) begin
                                state_next = crarmt_pkg::ST_BUILD;
                            end
                        end
                        crarmt_pkg::ACT_ADD: begin
                            op_next    = crarmt_pkg::OP_ADD;
                            state_next = crarmt_pkg::ST_PASS0;
                        end
                        crarmt_pkg::ACT_QUERY: begin
                            op_next    = crarmt_pkg::OP_QUERY;
                            state_next = crarmt_pkg::ST_PASS0;
                        end
                        default: state_next = crarmt_pkg::ST_IDLE;
                    endcase
                end
            end
            crarmt_pkg::ST_BUILD: begin
                cmd        = crarmt_pkg::CMD_BUILD;
                op_next    = crarmt_pkg::OP_BUILD;
                state_next = crarmt_pkg::ST_VISIT;
            end
            crarmt_pkg::ST_PASS0: begin
                cmd        = crarmt_pkg::CMD_PASS0;
                pass1_next = 1'b0;
                state_next = crarmt_pkg::ST_VISIT;
            end
            crarmt_pkg::ST_PASS1: begin
                cmd        = crarmt_pkg::CMD_PASS1;
                pass1_next = 1'b1;
                state_next = crarmt_pkg::ST_VISIT;
            end
            crarmt_pkg::ST_VISIT: begin
                if (status.empty) begin
                    if (op_reg == crarmt_pkg::OP_BUILD) begin
                        state_next = crarmt_pkg::ST_IDLE;
                    end else if (!pass1_reg && status.wrap) begin
                        state_next = crarmt_pkg::ST_PASS1;
                    end else if (op_reg == crarmt_pkg::OP_QUERY) begin
                        state_next = crarmt_pkg::ST_DONE;
                    end else begin
                        state_next = crarmt_pkg::ST_IDLE;
                    end
                end else begin
                    case (status.phase)
                        crarmt_pkg::PH_ENTER: begin
                            if (op_reg == crarmt_pkg::OP_BUILD) begin
                                if (status.leaf) begin
                                    state_next = crarmt_pkg::ST_LEAF_RD;
                                end else begin
                                    cmd = crarmt_pkg::CMD_DESC0;
                                end
                            end else if (status.disjoint) begin
                                cmd = crarmt_pkg::CMD_POP;
                            end else begin
                                cmd        = crarmt_pkg::CMD_RD_NODE;
                                state_next = crarmt_pkg::ST_NODE;
                            end
                        end
                        crarmt_pkg::PH_RIGHT: cmd = crarmt_pkg::CMD_DESC1;
                        crarmt_pkg::PH_POST: begin
                            if (op_reg == crarmt_pkg::OP_QUERY) begin
                                cmd = crarmt_pkg::CMD_POP;
                            end else begin
                                cmd        = crarmt_pkg::CMD_RD_C0;
                                state_next = crarmt_pkg::ST_POST_RD1;
                            end
                        end
                        default: cmd = crarmt_pkg::CMD_POP;
                    endcase
                end
            end
            crarmt_pkg::ST_NODE: begin
                state_next = crarmt_pkg::ST_VISIT;
                if (status.covered) begin
                    cmd = (op_reg == crarmt_pkg::OP_QUERY) ? crarmt_pkg::CMD_COVER_QRY
                                                           : crarmt_pkg::CMD_COVER_ADD;
                end else if (status.pend_nz) begin
                    cmd        = crarmt_pkg::CMD_SAVE_PEND;
                    state_next = crarmt_pkg::ST_PD_WR0;
                end else begin
                    cmd = crarmt_pkg::CMD_DESC0;
                end
            end
            crarmt_pkg::ST_PD_WR0: begin
                cmd        = crarmt_pkg::CMD_WR_C0;
                state_next = crarmt_pkg::ST_PD_WR1;
            end
            crarmt_pkg::ST_PD_WR1: begin
                cmd        = crarmt_pkg::CMD_WR_C1;
                state_next = crarmt_pkg::ST_VISIT;
            end
            crarmt_pkg::ST_LEAF_RD: begin
                cmd        = crarmt_pkg::CMD_RD_STG;
                state_next = crarmt_pkg::ST_LEAF_WR;
            end
            crarmt_pkg::ST_LEAF_WR: begin
                cmd        = crarmt_pkg::CMD_WR_LEAF;
                state_next = crarmt_pkg::ST_VISIT;
            end
            crarmt_pkg::ST_POST_RD1: begin
                cmd        = crarmt_pkg::CMD_RD_C1;
                state_next = crarmt_pkg::ST_POST_WR;
            end
            crarmt_pkg::ST_POST_WR: begin
                cmd        = crarmt_pkg::CMD_WR_POST;
                state_next = crarmt_pkg::ST_VISIT;
            end
            crarmt_pkg::ST_DONE: begin
                if (!status.out_busy) begin
                    cmd        = crarmt_pkg::CMD_OUT;
                    state_next = crarmt_pkg::ST_IDLE;
                end
            end
            default: state_next = crarmt_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/crarmt_dp.sv =====
// ----------------------------------------------------------------------------
// crarmt_dp
// Tree memories, node stack, saturating arithmetic and result register.
// ----------------------------------------------------------------------------
module crarmt_dp #(
    parameter int MAX_LENGTH  = crarmt_pkg::MAX_LENGTH,
    parameter int VALUE_WIDTH = crarmt_pkg::VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  crarmt_pkg::cmd_t              cmd,
    output crarmt_pkg::status_t           status,
    input  logic [crarmt_pkg::ACT_W-1:0]  s_action,
    input  logic [crarmt_pkg::IDX_W-1:0]  s_left,
    input  logic [crarmt_pkg::IDX_W-1:0]  s_right,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    input  logic [crarmt_pkg::LEN_W-1:0]  array_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_min_value
);

    localparam int IW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int NODES = 4 * MAX_LENGTH;
    localparam int NW    = $clog2(NODES);
    localparam int STK   = IW + 2;
    localparam int SPW   = $clog2(STK + 1);
    localparam int SIW   = $clog2(STK);
    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
        input logic signed [VALUE_WIDTH-1:0] a,
        input logic signed [VALUE_WIDTH-1:0] b
    );
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            sat_add = s[VALUE_WIDTH] ? VMIN : VMAX;
        end else begin
            sat_add = s[VALUE_WIDTH-1:0];
        end
    endfunction

    logic signed [VALUE_WIDTH-1:0] nmin_mem [NODES];
    logic signed [VALUE_WIDTH-1:0] pend_mem [NODES];
    logic signed [VALUE_WIDTH-1:0] stg_mem  [MAX_LENGTH];
    logic signed [VALUE_WIDTH-1:0] nmin_q, pend_q, stg_q;

    logic [NW-1:0]            stk_node_reg [STK];
    logic [IW-1:0]            stk_lo_reg   [STK];
    logic [IW-1:0]            stk_hi_reg   [STK];
    crarmt_pkg::phase_t       stk_ph_reg   [STK];
    logic [SPW-1:0]           sp_reg;

    logic [NW-1:0]                 clr_reg;
    logic [IW-1:0]                 top_reg;
    logic [crarmt_pkg::IDX_W-1:0]  left_reg, right_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg, push_reg, m0_reg, acc_reg;
    logic [IW-1:0]                 rl_reg, rr_reg;
    logic                          m_valid_reg;
    logic signed [VALUE_WIDTH-1:0] m_min_value_reg;

    logic [SIW-1:0]  tidx, pidx;
    logic [NW-1:0]   t_node, c0_node, c1_node, rd_addr;
    logic [IW-1:0]   t_lo, t_hi, mid, lc, rc, top_new;
    logic [IW:0]     mid_sum;
    logic            c0_leaf, c1_leaf, t_leaf, do_pop;

    logic                          nmin_we, pend_we, stg_we;
    logic [NW-1:0]                 nmin_wa, pend_wa;
    logic [IW-1:0]                 stg_wa;
    logic signed [VALUE_WIDTH-1:0] nmin_wd, pend_wd, stg_wd;

    assign tidx    = SIW'(sp_reg - SPW'(1));
    assign pidx    = SIW'(sp_reg);
    assign t_node  = stk_node_reg[tidx];
    assign t_lo    = stk_lo_reg[tidx];
    assign t_hi    = stk_hi_reg[tidx];
    assign c0_node = {t_node[NW-2:0], 1'b0};
    assign c1_node = {t_node[NW-2:0], 1'b1};
    assign mid_sum = {1'b0, t_lo} + {1'b0, t_hi};
    assign mid     = mid_sum[IW:1];
    assign t_leaf  = (t_lo == t_hi);
    assign c0_leaf = (t_lo == mid);
    assign c1_leaf = (({1'b0, mid} + (IW+1)'(1)) == {1'b0, t_hi});

    assign lc = (32'(left_reg) > 32'(top_reg)) ? top_reg : IW'(left_reg);
    assign rc = (32'(right_reg) > 32'(top_reg)) ? top_reg : IW'(right_reg);

    always_comb begin
        if (array_length == '0) begin
            top_new = '0;
        end else if (32'(array_length) > 32'(MAX_LENGTH)) begin
            top_new = IW'(MAX_LENGTH - 1);
        end else begin
            top_new = IW'(32'(array_length) - 32'd1);
        end
    end

    always_comb begin
        case (cmd)
            crarmt_pkg::CMD_RD_C0, crarmt_pkg::CMD_SAVE_PEND: rd_addr = c0_node;
            crarmt_pkg::CMD_RD_C1, crarmt_pkg::CMD_WR_C0:     rd_addr = c1_node;
            default:                                          rd_addr = t_node;
        endcase
    end

    assign do_pop = (cmd == crarmt_pkg::CMD_POP) || (cmd == crarmt_pkg::CMD_WR_LEAF) ||
                    (cmd == crarmt_pkg::CMD_COVER_ADD) || (cmd == crarmt_pkg::CMD_COVER_QRY) ||
                    (cmd == crarmt_pkg::CMD_WR_POST);

    always_comb begin
        nmin_we = 1'b0;
        nmin_wa = t_node;
        nmin_wd = '0;
        pend_we = 1'b0;
        pend_wa = t_node;
        pend_wd = '0;
        stg_we  = 1'b0;
        stg_wa  = IW'(s_left);
        stg_wd  = s_value;
        case (cmd)
            crarmt_pkg::CMD_CLEAR: begin
                pend_we = 1'b1;
                pend_wa = clr_reg;
                stg_we  = 1'b1;
                stg_wa  = clr_reg[IW-1:0];
                stg_wd  = '0;
            end
            crarmt_pkg::CMD_ACCEPT: begin
                stg_we = (s_action == crarmt_pkg::ACT_LOAD) &&
                         (32'(s_left) < 32'(MAX_LENGTH));
            end
            crarmt_pkg::CMD_WR_LEAF: begin
                nmin_we = 1'b1;
                nmin_wd = stg_q;
                pend_we = 1'b1;
            end
            crarmt_pkg::CMD_COVER_ADD: begin
                nmin_we = 1'b1;
                nmin_wd = sat_add(nmin_q, value_reg);
                pend_we = !t_leaf;
                pend_wd = sat_add(pend_q, value_reg);
            end
            crarmt_pkg::CMD_SAVE_PEND: begin
                pend_we = 1'b1;
            end
            crarmt_pkg::CMD_WR_C0, crarmt_pkg::CMD_WR_C1: begin
                nmin_we = 1'b1;
                nmin_wa = (cmd == crarmt_pkg::CMD_WR_C0) ? c0_node : c1_node;
                nmin_wd = sat_add(nmin_q, push_reg);
                pend_we = (cmd == crarmt_pkg::CMD_WR_C0) ? !c0_leaf : !c1_leaf;
                pend_wa = nmin_wa;
                pend_wd = sat_add(pend_q, push_reg);
            end
            crarmt_pkg::CMD_WR_POST: begin
                nmin_we = 1'b1;
                nmin_wd = (m0_reg < nmin_q) ? m0_reg : nmin_q;
                pend_we = 1'b1;
            end
            default: nmin_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        nmin_q <= nmin_mem[rd_addr];
        pend_q <= pend_mem[rd_addr];
        stg_q  <= stg_mem[t_lo];
        if (nmin_we) begin
            nmin_mem[nmin_wa] <= nmin_wd;
        end
        if (pend_we) begin
            pend_mem[pend_wa] <= pend_wd;
        end
        if (stg_we) begin
            stg_mem[stg_wa] <= stg_wd;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            crarmt_pkg::CMD_ACCEPT: begin
                left_reg  <= s_left;
                right_reg <= s_right;
                value_reg <= s_value;
            end
            crarmt_pkg::CMD_BUILD: begin
                top_reg         <= top_new;
                stk_node_reg[0] <= NW'(1);
                stk_lo_reg[0]   <= '0;
                stk_hi_reg[0]   <= top_new;
                stk_ph_reg[0]   <= crarmt_pkg::PH_ENTER;
            end
            crarmt_pkg::CMD_PASS0, crarmt_pkg::CMD_PASS1: begin
                stk_node_reg[0] <= NW'(1);
                stk_lo_reg[0]   <= '0;
                stk_hi_reg[0]   <= top_reg;
                stk_ph_reg[0]   <= crarmt_pkg::PH_ENTER;
                if (cmd == crarmt_pkg::CMD_PASS0) begin
                    acc_reg <= VMAX;
                    rl_reg  <= (rc < lc) ? '0 : lc;
                    rr_reg  <= rc;
                end else begin
                    rl_reg <= lc;
                    rr_reg <= top_reg;
                end
            end
            crarmt_pkg::CMD_COVER_QRY: begin
                acc_reg <= (nmin_q < acc_reg) ? nmin_q : acc_reg;
            end
            crarmt_pkg::CMD_SAVE_PEND: begin
                push_reg <= pend_q;
            end
            crarmt_pkg::CMD_RD_C1: begin
                m0_reg <= nmin_q;
            end
            crarmt_pkg::CMD_DESC0: begin
                stk_ph_reg[tidx]   <= crarmt_pkg::PH_RIGHT;
                stk_node_reg[pidx] <= c0_node;
                stk_lo_reg[pidx]   <= t_lo;
                stk_hi_reg[pidx]   <= mid;
                stk_ph_reg[pidx]   <= crarmt_pkg::PH_ENTER;
            end
            crarmt_pkg::CMD_DESC1: begin
                stk_ph_reg[tidx]   <= crarmt_pkg::PH_POST;
                stk_node_reg[pidx] <= c1_node;
                stk_lo_reg[pidx]   <= mid + IW'(1);
                stk_hi_reg[pidx]   <= t_hi;
                stk_ph_reg[pidx]   <= crarmt_pkg::PH_ENTER;
            end
            crarmt_pkg::CMD_OUT: begin
                m_min_value_reg <= acc_reg;
            end
            default: m0_reg <= m0_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd == crarmt_pkg::CMD_CLEAR) begin
                clr_reg <= clr_reg + NW'(1);
            end
            if ((cmd == crarmt_pkg::CMD_BUILD) || (cmd == crarmt_pkg::CMD_PASS0) ||
                (cmd == crarmt_pkg::CMD_PASS1)) begin
                sp_reg <= SPW'(1);
            end else if ((cmd == crarmt_pkg::CMD_DESC0) || (cmd == crarmt_pkg::CMD_DESC1)) begin
                sp_reg <= sp_reg + SPW'(1);
            end else if (do_pop) begin
                sp_reg <= sp_reg - SPW'(1);
            end
            if (cmd == crarmt_pkg::CMD_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_min_value = m_min_value_reg;

    always_comb begin
        status.clear_done = (clr_reg == NW'(NODES - 1));
        status.empty      = (sp_reg == '0);
        status.phase      = stk_ph_reg[tidx];
        status.leaf       = t_leaf;
        status.covered    = (rl_reg <= t_lo) && (t_hi <= rr_reg);
        status.disjoint   = (t_lo > rr_reg) || (t_hi < rl_reg);
        status.pend_nz    = (pend_q != '0);
        status.wrap       = (rc < lc);
        status.out_busy   = m_valid_reg && !m_ready;
    end

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> (sp_reg != '0))
        else $error("stack pop while empty");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd == crarmt_pkg::CMD_DESC0) || (cmd == crarmt_pkg::CMD_DESC1))
        |-> (sp_reg != '0) && (32'(sp_reg) < STK))
        else $error("stack overflow");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == crarmt_pkg::CMD_OUT) |-> !(m_valid_reg && !m_ready))
        else $error("pending result overwritten");

    a_start_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd == crarmt_pkg::CMD_PASS0) || (cmd == crarmt_pkg::CMD_BUILD)) |-> (sp_reg == '0))
        else $error("traversal started with stack in use");

    a_wr_child_after_save: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == crarmt_pkg::CMD_WR_C0) |-> ($past(cmd) == crarmt_pkg::CMD_SAVE_PEND))
        else $error("child write without saved addend");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the circular range-add / range-min tree. Loads and builds the tree,
// then runs range adds and circular range minimum queries. Every result is
// compared with a behavioral segment-tree predictor kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VW       = crarmt_pkg::VALUE_WIDTH;
    localparam int MAXLEN   = crarmt_pkg::MAX_LENGTH;
    localparam int IW       = crarmt_pkg::IDX_W;
    localparam int AW       = crarmt_pkg::APB_AW;
    localparam int NODES    = 4 * MAXLEN;
    localparam int ADDR_LEN = 0;
    localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    typedef struct {
        logic [crarmt_pkg::ACT_W-1:0] action;
        logic [IW-1:0]                left;
        logic [IW-1:0]                right;
        longint                       value;
        logic                         last;
        bit                           has_min;
        longint                       known_min;
    } row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [crarmt_pkg::ACT_W-1:0]     s_action = '0;
    logic [IW-1:0]                    s_left = '0;
    logic [IW-1:0]                    s_right = '0;
    logic signed [VW-1:0]             s_value = '0;
    logic                             s_last_load = 1'b0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [VW-1:0]             m_min_value;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [AW-1:0]                    paddr = '0;
    logic [crarmt_pkg::APB_DW-1:0]    pwdata = '0;
    logic [crarmt_pkg::APB_DW-1:0]    prdata;
    logic                             pready;

    circular_range_add_range_min_tree DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    int unsigned length_reg;
    int unsigned tree_len;
    longint      tree_min [NODES];
    longint      lazy_add [NODES];
    bit          lazy_on  [NODES];
    longint      staged   [MAXLEN];

    longint      min_queue [$];
    int          errors = 0;
    bit          quiet = 1'b0;

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > VMAX) return VMAX;
        if (s < VMIN) return VMIN;
        return s;
    endfunction

    function automatic longint lower(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic void apply_add(int n, int lo, int hi, longint a);
        if (lo != hi) begin
            lazy_on[n]  = 1'b1;
            lazy_add[n] = sat_sum(lazy_add[n], a);
        end
        tree_min[n] = sat_sum(tree_min[n], a);
    endfunction

    function automatic void push_lazy(int n, int lo, int hi);
        int mid;
        if (!lazy_on[n]) return;
        lazy_on[n] = 1'b0;
        mid = (lo + hi) / 2;
        apply_add(2 * n, lo, mid, lazy_add[n]);
        apply_add(2 * n + 1, mid + 1, hi, lazy_add[n]);
        lazy_add[n] = 0;
    endfunction

    function automatic void build_tree(int n, int lo, int hi);
        int mid;
        if (lo == hi) begin
            tree_min[n] = staged[lo];
            return;
        end
        mid = (lo + hi) / 2;
        build_tree(2 * n, lo, mid);
        build_tree(2 * n + 1, mid + 1, hi);
        tree_min[n] = lower(tree_min[2 * n], tree_min[2 * n + 1]);
    endfunction

    function automatic longint range_min(int n, int lo, int hi, int l, int r);
        int mid;
        if (lo > r || hi < l) return VMAX;
        if (l <= lo && hi <= r) return tree_min[n];
        push_lazy(n, lo, hi);
        mid = (lo + hi) / 2;
        return lower(range_min(2 * n, lo, mid, l, r),
                     range_min(2 * n + 1, mid + 1, hi, l, r));
    endfunction

    function automatic void range_add(int n, int lo, int hi, int l, int r, longint a);
        int mid;
        if (l <= lo && hi <= r) begin
            apply_add(n, lo, hi, a);
            return;
        end
        if (lo > r || hi < l) return;
        push_lazy(n, lo, hi);
        mid = (lo + hi) / 2;
        range_add(2 * n, lo, mid, l, r, a);
        range_add(2 * n + 1, mid + 1, hi, l, r, a);
        tree_min[n] = lower(tree_min[2 * n], tree_min[2 * n + 1]);
    endfunction

    // returns 1 and the expected minimum when the transaction yields a result
    function automatic bit predict_min(row_t t, output longint m);
        int top, l, r;
        m = 0;
        if (t.action == crarmt_pkg::ACT_LOAD) begin
            staged[t.left] = t.value;
            if (t.last) begin
                tree_len = (length_reg == 0) ? 1 :
                           (length_reg > MAXLEN) ? MAXLEN : length_reg;
                for (int i = 0; i < NODES; i++) begin
                    lazy_add[i] = 0;
                    lazy_on[i]  = 1'b0;
                end
                build_tree(1, 0, tree_len - 1);
            end
            return 1'b0;
        end
        if (t.action != crarmt_pkg::ACT_ADD && t.action != crarmt_pkg::ACT_QUERY) return 1'b0;
        top = tree_len - 1;
        l = (t.left > top) ? top : t.left;
        r = (t.right > top) ? top : t.right;
        if (t.action == crarmt_pkg::ACT_ADD) begin
            if (r < l) begin
                range_add(1, 0, top, 0, r, t.value);
                range_add(1, 0, top, l, top, t.value);
            end else begin
                range_add(1, 0, top, l, r, t.value);
            end
            return 1'b0;
        end
        if (r < l)
            m = lower(range_min(1, 0, top, 0, r), range_min(1, 0, top, l, top));
        else
            m = range_min(1, 0, top, l, r);
        return 1'b1;
    endfunction

    task automatic idle_burst(input int pct);
        if (!quiet && $urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge aclk);
        end
    endtask

    task automatic send(row_t t);
        longint m;
        if (predict_min(t, m)) begin
            if (t.has_min && m != t.known_min) begin
                $display("%0t table mismatch: expected %0d, predictor %0d",
                         $time, t.known_min, m);
                errors++;
            end
            min_queue = {min_queue, m};
        end
        s_valid     <= 1'b1;
        s_action    <= t.action;
        s_left      <= t.left;
        s_right     <= t.right;
        s_value     <= t.value[VW-1:0];
        s_last_load <= t.last;
        do @(posedge aclk); while (!s_ready);
        idle_burst(20);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (min_queue.size() != 0 || !s_ready);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_length(int unsigned v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= AW'(ADDR_LEN);
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        length_reg = v & 11'h7FF;
    endtask

    function automatic row_t mk(logic [crarmt_pkg::ACT_W-1:0] a, int l, int r, longint v,
                                bit last, bit has = 0, longint km = 0);
        row_t t;
        t.action = a; t.left = IW'(l); t.right = IW'(r); t.value = v; t.last = last;
        t.has_min = has; t.known_min = km;
        return t;
    endfunction

    function automatic longint rand_value(int mode);
        longint v;
        v = {$urandom, $urandom};
        case (mode)
            0: return VMAX;
            1: return VMIN;
            2: return longint'($urandom_range(200)) - 100;
            default: return (v <<< 16) >>> 16;
        endcase
    endfunction

    // loads the first n elements, the last one builds
    task automatic load_all(int n, int mode);
        for (int i = 0; i < n; i++)
            send(mk(crarmt_pkg::ACT_LOAD, i, $urandom,
                    rand_value(mode == 3 ? $urandom_range(3) : mode), i == n - 1));
    endtask

    task automatic random_ops(int count, int n);
        logic [crarmt_pkg::ACT_W-1:0] a;
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            a = (k < 45) ? crarmt_pkg::ACT_QUERY : (k < 85) ? crarmt_pkg::ACT_ADD :
                (k < 90) ? crarmt_pkg::ACT_LOAD : crarmt_pkg::ACT_UNUSED;
            if (a == crarmt_pkg::ACT_LOAD && $urandom_range(3) == 0 && n < MAXLEN)
                send(mk(a, $urandom_range(MAXLEN - 1), $urandom, rand_value(3),
                        1'($urandom_range(1))));
            else if (a == crarmt_pkg::ACT_LOAD)
                send(mk(a, $urandom_range(n - 1), $urandom, rand_value(3), 1'b0));
            else if ($urandom_range(9) == 0)
                send(mk(a, $urandom, $urandom, rand_value($urandom_range(3)),
                        1'($urandom)));
            else
                send(mk(a, $urandom_range(n - 1), $urandom_range(n - 1),
                        rand_value($urandom_range(9) == 0 ? $urandom_range(1)
                                                          : 2 + $urandom_range(1)),
                        1'($urandom)));
        end
    endtask

    // result side
    always @(posedge aclk) begin
        longint want;
        if (aresetn && m_valid && m_ready) begin
            if (min_queue.size() == 0) begin
                $display("%0t unexpected result: actual %0d", $time, m_min_value);
                errors++;
            end else begin
                want = min_queue.pop_front();
                if (longint'(m_min_value) != want) begin
                    $display("%0t min_value mismatch: expected %0d, actual %0d",
                             $time, want, m_min_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (quiet || $urandom_range(99) >= 25) begin
            m_ready <= 1'b1;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(9, 1) - 1) @(posedge aclk);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #400ms;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        int lens [6] = '{1024, 1, 2, 7, 33, 100};
        length_reg = 1024;
        tree_len   = 1024;
        for (int i = 0; i < NODES; i++) begin
            tree_min[i] = 0; lazy_add[i] = 0; lazy_on[i] = 0;
        end
        foreach (staged[i]) staged[i] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: length 4 table
        write_length(4);
        begin
            row_t tbl [$];
            tbl = {
                mk(crarmt_pkg::ACT_LOAD, 0, 0, 5, 0),
                mk(crarmt_pkg::ACT_LOAD, 1, 0, -3, 0),
                mk(crarmt_pkg::ACT_LOAD, 2, 0, VMAX, 0),
                mk(crarmt_pkg::ACT_LOAD, 1023, 0, 9, 0),
                mk(crarmt_pkg::ACT_LOAD, 3, 1023, VMIN, 1),
                mk(crarmt_pkg::ACT_QUERY, 0, 3, 0, 0, 1, VMIN),
                mk(crarmt_pkg::ACT_QUERY, 0, 1, 0, 1, 1, -3),
                mk(crarmt_pkg::ACT_QUERY, 2, 2, 0, 0, 1, VMAX),
                mk(crarmt_pkg::ACT_QUERY, 1023, 1023, 0, 0, 1, VMIN),
                mk(crarmt_pkg::ACT_QUERY, 2, 0, 0, 0, 1, VMIN),
                mk(crarmt_pkg::ACT_UNUSED, 0, 3, 77, 1),
                mk(crarmt_pkg::ACT_ADD, 2, 2, 1, 0),
                mk(crarmt_pkg::ACT_QUERY, 2, 2, 0, 0, 1, VMAX),
                mk(crarmt_pkg::ACT_ADD, 3, 3, -1, 0),
                mk(crarmt_pkg::ACT_QUERY, 3, 3, 0, 0, 1, VMIN),
                mk(crarmt_pkg::ACT_ADD, 3, 0, VMAX, 1),
                mk(crarmt_pkg::ACT_QUERY, 3, 1, 0, 0),
                mk(crarmt_pkg::ACT_ADD, 1, 2, VMIN, 0),
                mk(crarmt_pkg::ACT_QUERY, 0, 3, 0, 0),
                mk(crarmt_pkg::ACT_ADD, 1023, 0, 12345, 0),
                mk(crarmt_pkg::ACT_QUERY, 1, 1023, 0, 0),
                mk(crarmt_pkg::ACT_QUERY, 0, 0, 0, 0)
            };
            foreach (tbl[i]) send(tbl[i]);
        end
        drain();

        // random phases over several lengths, small trees mostly
        for (int p = 0; p < 6; p++) begin
            write_length(lens[p]);
            load_all(lens[p] > 256 ? 256 : lens[p], p == 2 ? 0 : 3);
            random_ops(lens[p] == 1024 ? 60 : 140, lens[p]);
            drain();
        end
        write_length(0);
        load_all(1, 3);
        random_ops(20, 1);
        drain();
        write_length(2047);
        send(mk(crarmt_pkg::ACT_LOAD, 5, 0, -7, 1));
        random_ops(20, 1024);
        drain();

        // quiet finish
        write_length(16);
        load_all(16, 3);
        quiet = 1'b1;
        random_ops(80, 16);
        drain();

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
